// ===== hw/rtl/snae_pkg.sv =====
// Package for the sparse n-gram extractor: request and response payload types,
// field widths and hash constants. No dependencies.
package snae_pkg;

   localparam int BYTE_BITS   = 8;
   localparam int HASH_BITS   = 32;
   localparam int START_BITS  = 16;
   localparam int LENGTH_BITS = 17;

   localparam logic [63:0] MUL_FIRST  = 64'hc6a4a7935bd1e995;
   localparam logic [63:0] MUL_SECOND = 64'h0228876a7198b743;
   localparam int          FOLD_SHIFT = 47;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic                 end_of_string;
   } req_type;

   typedef struct packed {
      logic [START_BITS-1:0]  ngram_start;
      logic [LENGTH_BITS-1:0] ngram_length;
      logic                   overflow;
      logic                   last_of_run;
   } rsp_type;

endpackage

// ===== hw/rtl/snae_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module snae_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sparse_ngram_all_extractor.sv =====
// Sparse n-gram extractor (all n-grams): pair hash and monotonic stack.
// Depends on snae_pkg and snae_ram.
//
//   channel | ports                        | moves
//   req     | req_valid req_ready req_data | one text byte and end flag
//   rsp     | rsp_valid rsp_ready rsp_data | one n-gram (start, length, flags)
//   csr     | csr_valid csr_ready csr_wdata| signed_bytes register
//
// The first byte of a string is taken in the accept step alone. Other bytes: accept,
// hash on the shared 8x64 multiplier (MUL1, MUL2, SUM, FOLD), a compare per stack
// top tested, a check and, while entries remain, a stack RAM read per popped or
// discarded stack entry, a result step per result, then a push.
// Reset is synchronous; it empties the stack by count, the RAM is not cleared.
// A stalled rsp holds the sequencer in its result state; req_ready is low
// whenever a byte is in work.
module sparse_ngram_all_extractor
   import snae_pkg::*;
#(
   parameter int STACK_DEPTH   = 32,
   parameter int POSITION_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_wdata
);

   localparam int IW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int PB = POSITION_BITS;
   localparam int RW = HASH_BITS + PB;
   localparam int WB = (PB + 1 > LENGTH_BITS) ? PB + 1 : LENGTH_BITS;
   localparam int SB = (PB > START_BITS) ? PB : START_BITS;
   localparam logic [IW:0]   DEPTH_W = (IW + 1)'(STACK_DEPTH);
   localparam logic [IW-1:0] LAST_SLOT = IW'(STACK_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MUL1 = 4'd1;
   localparam logic [3:0] ST_MUL2 = 4'd2;
   localparam logic [3:0] ST_SUM  = 4'd3;
   localparam logic [3:0] ST_FOLD = 4'd4;
   localparam logic [3:0] ST_CMP  = 4'd5;
   localparam logic [3:0] ST_CHK  = 4'd6;
   localparam logic [3:0] ST_RDW  = 4'd7;
   localparam logic [3:0] ST_EPOP = 4'd8;
   localparam logic [3:0] ST_ETOP = 4'd9;
   localparam logic [3:0] ST_PUSH = 4'd10;

   logic [3:0]           state_ff, state_in;
   logic                 signed_bytes_ff, signed_bytes_in;
   logic [BYTE_BITS-1:0] prev_byte_ff, prev_byte_in;
   logic                 have_prev_ff, have_prev_in;
   logic [PB-1:0]        pos_ff, pos_in;
   logic [IW-1:0]        base_ff, base_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [BYTE_BITS-1:0] cur_byte_ff, cur_byte_in;
   logic                 eos_ff, eos_in;
   logic [63:0]          prod_ff, prod_in;
   logic [63:0]          acc_ff, acc_in;
   logic [HASH_BITS-1:0] hash_ff, hash_in;
   logic [HASH_BITS-1:0] top_hash_ff, top_hash_in;
   logic [PB-1:0]        top_start_ff, top_start_in;
   logic [HASH_BITS-1:0] pop_hash_ff, pop_hash_in;
   logic [PB-1:0]        pend_start_ff, pend_start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [BYTE_BITS-1:0] mul_byte;
   logic [63:0]          mul_const, mul_full, mul_out, acc_inv;
   logic [IW:0]          sum_top, sum_cnt;
   logic [IW-1:0]        phys_top, phys_cnt, base_next;
   logic [PB:0]          end1;
   logic [PB-1:0]        pair_start, emit_start;
   logic [WB-1:0]        len_wide;
   logic [SB-1:0]        start_wide;
   logic                 rsp_free, emit, emit_last;
   logic                 finish, fin_eos;
   logic [BYTE_BITS-1:0] fin_byte;
   logic                 ram_wr_en, ram_rd_en;
   logic [IW-1:0]        ram_wr_addr;
   logic [RW-1:0]        ram_wr_data, ram_rd_data;
   logic [HASH_BITS-1:0] rd_hash;
   logic [PB-1:0]        rd_start;

   snae_ram #(
      .WIDTH(RW),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(phys_top),
      .rd_data(ram_rd_data)
   );

   assign rd_hash  = ram_rd_data[RW-1:PB];
   assign rd_start = ram_rd_data[PB-1:0];

   // shared byte-by-constant multiplier; sign extension folded in as -(C << 8)
   always_comb begin
      mul_byte  = (state_ff == ST_MUL1) ? prev_byte_ff : cur_byte_ff;
      mul_const = (state_ff == ST_MUL1) ? MUL_FIRST : MUL_SECOND;
      mul_full  = {{(64 - BYTE_BITS){1'b0}}, mul_byte} * mul_const;
      mul_out   = mul_full -
                  ((signed_bytes_ff && mul_byte[BYTE_BITS-1]) ? (mul_const << 8) : 64'd0);
      acc_inv   = (~acc_ff) >> FOLD_SHIFT;
   end

   // circular stack addressing
   always_comb begin
      sum_top   = {1'b0, base_ff} + {1'b0, IW'(count_ff - 1'b1)};
      sum_cnt   = {1'b0, base_ff} + {1'b0, IW'(count_ff)};
      phys_top  = (sum_top >= DEPTH_W) ? IW'(sum_top - DEPTH_W) : sum_top[IW-1:0];
      phys_cnt  = (sum_cnt >= DEPTH_W) ? IW'(sum_cnt - DEPTH_W) : sum_cnt[IW-1:0];
      base_next = (base_ff == LAST_SLOT) ? '0 : base_ff + 1'b1;
   end

   always_comb begin
      end1       = {1'b0, pos_ff} + 1'b1;
      pair_start = (pos_ff == '0) ? '0 : pos_ff - 1'b1;
      emit_start = (state_ff == ST_EPOP) ? pend_start_ff : top_start_ff;
      len_wide   = WB'(end1) - WB'(emit_start);
      start_wide = SB'(emit_start);
   end

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in        = state_ff;
      signed_bytes_in = signed_bytes_ff;
      prev_byte_in    = prev_byte_ff;
      have_prev_in    = have_prev_ff;
      pos_in          = pos_ff;
      base_in         = base_ff;
      count_in        = count_ff;
      ovf_in          = ovf_ff;
      cur_byte_in     = cur_byte_ff;
      eos_in          = eos_ff;
      prod_in         = prod_ff;
      acc_in          = acc_ff;
      hash_in         = hash_ff;
      top_hash_in     = top_hash_ff;
      top_start_in    = top_start_ff;
      pop_hash_in     = pop_hash_ff;
      pend_start_in   = pend_start_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;
      emit            = 1'b0;
      emit_last       = 1'b0;
      finish          = 1'b0;
      fin_eos         = 1'b0;
      fin_byte        = cur_byte_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = phys_cnt;
      ram_wr_data     = {hash_ff, pair_start};
      ram_rd_en       = 1'b0;

      if (csr_valid) begin
         signed_bytes_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_byte_in = req_data.data_byte;
               eos_in      = req_data.end_of_string;
               if (have_prev_ff) begin
                  state_in = ST_MUL1;
               end else begin
                  finish   = 1'b1;
                  fin_byte = req_data.data_byte;
                  fin_eos  = req_data.end_of_string;
               end
            end
         end
         ST_MUL1: begin
            prod_in  = mul_out;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            acc_in   = prod_ff;
            prod_in  = mul_out;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            acc_in   = acc_ff + prod_ff;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            hash_in  = acc_ff[HASH_BITS-1:0] + acc_inv[HASH_BITS-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (count_ff == '0) begin
               state_in = ST_PUSH;
            end else if (hash_ff > top_hash_ff) begin
               pend_start_in = top_start_ff;
               pop_hash_in   = top_hash_ff;
               count_in      = count_ff - 1'b1;
               state_in      = ST_CHK;
            end else begin
               state_in = ST_ETOP;
            end
         end
         ST_CHK: begin
            if (count_ff == '0) begin
               state_in = ST_EPOP;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_RDW;
            end
         end
         ST_RDW: begin
            top_hash_in  = rd_hash;
            top_start_in = rd_start;
            if (rd_hash == pop_hash_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_CHK;
            end else begin
               state_in = ST_EPOP;
            end
         end
         ST_EPOP: begin
            if (rsp_free) begin
               emit      = 1'b1;
               emit_last = (count_ff == '0);
               state_in  = (count_ff == '0) ? ST_PUSH : ST_CMP;
            end
         end
         ST_ETOP: begin
            if (rsp_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               state_in  = ST_PUSH;
            end
         end
         ST_PUSH: begin
            ram_wr_en    = 1'b1;
            top_hash_in  = hash_ff;
            top_start_in = pair_start;
            if (count_ff == DEPTH_C) begin
               ram_wr_addr = base_ff;
               base_in     = base_next;
               ovf_in      = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
            finish   = 1'b1;
            fin_eos  = eos_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.ngram_start  = start_wide[START_BITS-1:0];
         rsp_data_in.ngram_length = len_wide[LENGTH_BITS-1:0];
         rsp_data_in.overflow     = ovf_ff;
         rsp_data_in.last_of_run  = emit_last;
      end

      if (finish) begin
         prev_byte_in = fin_byte;
         have_prev_in = 1'b1;
         if (pos_ff != '1) begin
            pos_in = pos_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
         if (fin_eos) begin
            prev_byte_in = '0;
            have_prev_in = 1'b0;
            pos_in       = '0;
            base_in      = '0;
            count_in     = '0;
            ovf_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         signed_bytes_ff <= 1'b1;
         prev_byte_ff    <= '0;
         have_prev_ff    <= 1'b0;
         pos_ff          <= '0;
         base_ff         <= '0;
         count_ff        <= '0;
         ovf_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         signed_bytes_ff <= signed_bytes_in;
         prev_byte_ff    <= prev_byte_in;
         have_prev_ff    <= have_prev_in;
         pos_ff          <= pos_in;
         base_ff         <= base_in;
         count_ff        <= count_in;
         ovf_ff          <= ovf_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_byte_ff   <= cur_byte_in;
      eos_ff        <= eos_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      hash_ff       <= hash_in;
      top_hash_ff   <= top_hash_in;
      top_start_ff  <= top_start_in;
      pop_hash_ff   <= pop_hash_in;
      pend_start_ff <= pend_start_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

// ===== bench/sparse_ngram_all_extractor_tb.sv =====
// Self-checking bench for sparse_ngram_all_extractor: drives text bytes, predicts
// every n-gram from a local hash and monotonic stack model, checks each response.
// Depends on snae_pkg and the extractor RTL.
`timescale 1ns / 1ps

module sparse_ngram_all_extractor_tb;
   import snae_pkg::*;

   localparam int          TEXT_STACK_DEPTH = 32;
   localparam logic [15:0] POS_LIMIT        = 16'hFFFF;
   localparam int          CHAIN_PAIRS      = 33;
   localparam int          SETTLE_CYCLES    = 16;
   localparam int          DRAIN_LIMIT      = 200000;
   localparam int          RANDOM_ITEMS     = 45;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_wdata;

   // predictor state
   bit          sign_extend = 1'b1;
   logic [7:0]  last_byte   = '0;
   bit          have_last   = 1'b0;
   logic [15:0] next_pos    = '0;
   logic [31:0] mono_hash[$];
   logic [15:0] mono_start[$];
   bit          dropped     = 1'b0;

   rsp_type expected_ngrams[$];
   int      mismatches     = 0;
   int      ngrams_checked = 0;
   int      bytes_sent     = 0;
   int      strings_sent   = 0;
   bit      string_open    = 1'b0;
   bit      pacing         = 1'b1;

   sparse_ngram_all_extractor DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic logic [31:0] pair_hash(logic [7:0] b0, logic [7:0] b1);
      logic [63:0] w0, w1, a, folded;
      w0 = sign_extend ? {{56{b0[7]}}, b0} : {56'd0, b0};
      w1 = sign_extend ? {{56{b1[7]}}, b1} : {56'd0, b1};
      a = w0 * MUL_FIRST + w1 * MUL_SECOND;
      folded = a + ((~a) >> FOLD_SHIFT);
      return folded[31:0];
   endfunction

   function automatic rsp_type make_ngram(logic [15:0] start, logic [16:0] end1);
      rsp_type r;
      r.ngram_start  = start;
      r.ngram_length = end1 - {1'b0, start};
      r.overflow     = dropped;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   task automatic predict_ngrams(input req_type item);
      rsp_type     run[$];
      rsp_type     r;
      logic [31:0] h;
      logic [15:0] start;
      logic [16:0] end1;
      if (have_last) begin
         h = pair_hash(last_byte, item.data_byte);
         start = (next_pos > 0) ? next_pos - 16'd1 : 16'd0;
         end1 = {1'b0, next_pos} + 17'd1;
         while (mono_hash.size() > 0 && h > mono_hash[$]) begin
            run.insert(run.size(), make_ngram(mono_start[$], end1));
            // equal hashes glued below the top go without a result
            while (mono_hash.size() > 1 && mono_hash[$] == mono_hash[$-1]) begin
               mono_hash.delete(mono_hash.size() - 1);
               mono_start.delete(mono_start.size() - 1);
            end
            mono_hash.delete(mono_hash.size() - 1);
            mono_start.delete(mono_start.size() - 1);
         end
         if (mono_hash.size() > 0)
            run.insert(run.size(), make_ngram(mono_start[$], end1));
         if (mono_hash.size() >= TEXT_STACK_DEPTH) begin
            mono_hash.delete(0);
            mono_start.delete(0);
            dropped = 1'b1;
         end
         mono_hash.insert(mono_hash.size(), h);
         mono_start.insert(mono_start.size(), start);
      end
      foreach (run[k]) begin
         r = run[k];
         r.last_of_run = (k == run.size() - 1);
         expected_ngrams.insert(expected_ngrams.size(), r);
      end
      last_byte = item.data_byte;
      have_last = 1'b1;
      if (next_pos != POS_LIMIT)
         next_pos++;
      else
         dropped = 1'b1;
      if (item.end_of_string) begin
         last_byte = '0;
         have_last = 1'b0;
         next_pos = '0;
         mono_hash.delete();
         mono_start.delete();
         dropped = 1'b0;
      end
   endtask

   // called at a rising edge; returns at the edge that accepts the request
   task automatic send_text_byte(input logic [7:0] b, input logic eos);
      int gap;
      req_type item;
      gap = pacing ? $urandom_range(0, 17) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.data_byte = b;
      item.end_of_string = eos;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      predict_ngrams(item);
      bytes_sent++;
      if (eos)
         strings_sent++;
      string_open = !eos;
   endtask

   task automatic settle_block();
      int waited;
      req_valid <= 1'b0;
      for (waited = 0; expected_ngrams.size() != 0 && waited < DRAIN_LIMIT; waited++)
         @(posedge clock);
      if (expected_ngrams.size() != 0) begin
         $error("%0d expected n-grams never arrived", expected_ngrams.size());
         mismatches++;
         expected_ngrams.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_signed_bytes(input logic mode);
      settle_block();
      csr_valid <= 1'b1;
      csr_wdata <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sign_extend = mode;
   endtask

   task automatic close_string();
      if (string_open)
         send_text_byte(8'($urandom), 1'b1);
   endtask

   // highest-hash pair and the pair with the next lower hash, current mode
   task automatic find_peak_pairs(output logic [7:0] px, py, qx, qy);
      logic [31:0] h, peak, runner;
      peak = '0;
      runner = '0;
      px = '0; py = '0; qx = '0; qy = '0;
      for (int x = 0; x < 256; x++) begin
         for (int y = 0; y < 256; y++) begin
            h = pair_hash(8'(x), 8'(y));
            if (h > peak) begin
               runner = peak; qx = px; qy = py;
               peak = h; px = 8'(x); py = 8'(y);
            end else if (h > runner && h < peak) begin
               runner = h; qx = 8'(x); qy = 8'(y);
            end
         end
      end
   endtask

   task automatic test_short_strings();
      send_text_byte(8'hFF, 1'b1);
      send_text_byte(8'h00, 1'b0);
      send_text_byte(8'hFF, 1'b1);
      send_text_byte(8'h80, 1'b0);
      send_text_byte(8'h7F, 1'b0);
      send_text_byte(8'h01, 1'b1);
      send_text_byte(8'hFF, 1'b0);
      send_text_byte(8'h00, 1'b0);
      send_text_byte(8'h80, 1'b0);
      send_text_byte(8'h7F, 1'b1);
   endtask

   task automatic test_byte_extension();
      write_signed_bytes(1'b0);
      send_text_byte(8'h80, 1'b0);
      send_text_byte(8'hFF, 1'b0);
      send_text_byte(8'h00, 1'b0);
      send_text_byte(8'h7F, 1'b0);
      send_text_byte(8'hFF, 1'b1);
      write_signed_bytes(1'b1);
      send_text_byte(8'h80, 1'b0);
      send_text_byte(8'hFF, 1'b0);
      send_text_byte(8'h00, 1'b0);
      send_text_byte(8'h7F, 1'b0);
      send_text_byte(8'hFF, 1'b1);
   endtask

   task automatic test_equal_run_discard();
      logic [7:0] px, py, qx, qy;
      find_peak_pairs(px, py, qx, qy);
      repeat (5) send_text_byte(8'h5A, 1'b0);
      send_text_byte(px, 1'b0);
      send_text_byte(py, 1'b1);
   endtask

   // strictly falling pair hashes overfill the stack, then the peak pair unwinds it
   task automatic test_stack_overflow_unwind();
      logic [7:0]  px, py, qx, qy, c;
      logic [7:0]  chain[CHAIN_PAIRS+1];
      logic [31:0] peak, floor_hash, best, h;
      bit          found;
      int          first;
      find_peak_pairs(px, py, qx, qy);
      peak = pair_hash(px, py);
      chain[CHAIN_PAIRS] = px;
      floor_hash = '0;
      first = 0;
      for (int i = CHAIN_PAIRS - 1; i >= 0; i--) begin
         found = 1'b0;
         best = '1;
         for (int k = 0; k < 256; k++) begin
            c = 8'(k);
            h = pair_hash(c, chain[i+1]);
            if ((i == CHAIN_PAIRS - 1 || h > floor_hash) && h < peak && (!found || h < best)) begin
               found = 1'b1;
               best = h;
               chain[i] = c;
            end
         end
         if (!found) begin
            first = i + 1;
            break;
         end
         floor_hash = best;
      end
      for (int i = first; i <= CHAIN_PAIRS; i++)
         send_text_byte(chain[i], 1'b0);
      send_text_byte(py, 1'b1);
   endtask

   task automatic test_random_strings();
      int         sent, len, kind;
      logic [7:0] b, run_byte;
      bit         hi, lo;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0)
            write_signed_bytes(1'($urandom_range(0, 1)));
         pacing = ($urandom_range(0, 3) != 0);
         len = $urandom_range(1, 14);
         kind = $urandom_range(0, 3);
         run_byte = 8'($urandom);
         for (int i = 0; i < len; i++) begin
            hi = 1'($urandom_range(0, 1));
            lo = 1'($urandom_range(0, 1));
            case (kind)
               0: b = 8'($urandom);
               1: b = ($urandom_range(0, 2) == 0) ? 8'($urandom) : run_byte;
               2: b = {hi, {7{lo}}};
               default: b = hi ? run_byte : run_byte ^ 8'h80;
            endcase
            // a few strings run on into the next one
            send_text_byte(b, (i == len - 1) && ($urandom_range(0, 5) != 0));
            sent++;
         end
      end
      pacing = 1'b1;
      close_string();
   endtask

   initial begin : rsp_pacer
      int stall;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         stall = pacing ? $urandom_range(0, 17) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_ngrams.size() == 0) begin
            $error("unexpected n-gram: start %0d length %0d",
                   rsp_data.ngram_start, rsp_data.ngram_length);
            mismatches++;
         end else begin
            if (rsp_data.ngram_start !== expected_ngrams[0].ngram_start) begin
               $error("ngram_start: expected %0d, got %0d",
                      expected_ngrams[0].ngram_start, rsp_data.ngram_start);
               mismatches++;
            end
            if (rsp_data.ngram_length !== expected_ngrams[0].ngram_length) begin
               $error("ngram_length: expected %0d, got %0d",
                      expected_ngrams[0].ngram_length, rsp_data.ngram_length);
               mismatches++;
            end
            if (rsp_data.overflow !== expected_ngrams[0].overflow) begin
               $error("overflow: expected %0b, got %0b",
                      expected_ngrams[0].overflow, rsp_data.overflow);
               mismatches++;
            end
            if (rsp_data.last_of_run !== expected_ngrams[0].last_of_run) begin
               $error("last_of_run: expected %0b, got %0b",
                      expected_ngrams[0].last_of_run, rsp_data.last_of_run);
               mismatches++;
            end
            expected_ngrams.delete(0);
            ngrams_checked++;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_wdata <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_short_strings();
      test_byte_extension();
      test_equal_run_discard();
      test_stack_overflow_unwind();
      test_random_strings();
      settle_block();
      $display("sent %0d bytes in %0d strings, both byte extension modes", bytes_sent,
               strings_sent);
      $display("checked %0d n-grams incl. equal-hash discards and stack overflow",
               ngrams_checked);
      if (mismatches == 0)
         $display("sparse_ngram_all_extractor_tb passed");
      else
         $display("sparse_ngram_all_extractor_tb failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("sparse_ngram_all_extractor_tb failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/snae_pkg.sv
hw/rtl/snae_ram.sv
hw/rtl/sparse_ngram_all_extractor.sv
bench/sparse_ngram_all_extractor_tb.sv
